[sv/gdb_pkg.sv]
// Shared types, constants and command/status structs for the greedy denomination breakdown.
package gdb_pkg;

	localparam int SLOTS     = 8;
	localparam int SLOT_W    = 3;
	localparam int NUM_DENOM = 8;
	localparam int VAL_W     = 31;
	localparam int CNT_W     = 32;
	localparam int DIV_CNT_W = 5;

	localparam logic REQ_ADD   = 1'b0;
	localparam logic REQ_QUERY = 1'b1;

	typedef struct packed {
		logic             req_type;
		logic [VAL_W-1:0] amount_cents;
		logic [VAL_W-1:0] query_value;
	} req_t;

	typedef struct packed {
		logic             found;
		logic [CNT_W-1:0] unit_count;
		logic [VAL_W-1:0] leftover_cents;
	} res_t;

	typedef struct packed {
		logic load;
		logic scan_step;
		logic div_start;
		logic update;
		logic emit;
	} gdb_cmd_t;

	typedef struct packed {
		logic scan_last;
		logic best_vld;
		logic div_done;
	} gdb_stat_t;

endpackage

[sv/gdb_div.sv]
// Iterative restoring divider, one quotient bit per cycle.
module gdb_div import gdb_pkg::*; (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             start,
	input  logic [VAL_W-1:0] dividend,
	input  logic [VAL_W-1:0] divisor,
	output logic             done,
	output logic [VAL_W-1:0] quotient,
	output logic [VAL_W-1:0] remainder
);

	logic [VAL_W-1:0]     rem_q;
	logic [VAL_W-1:0]     quo_q;
	logic [DIV_CNT_W-1:0] cnt_q;
	logic                 run_q;
	logic                 done_q;
	logic [VAL_W:0]       trial;
	logic [VAL_W:0]       diff;
	logic                 ge;

	assign trial = {rem_q, quo_q[VAL_W-1]};
	assign ge    = trial >= {1'b0, divisor};
	assign diff  = trial - {1'b0, divisor};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			run_q  <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				run_q <= 1'b1;
				cnt_q <= DIV_CNT_W'(VAL_W - 1);
			end else if (run_q) begin
				cnt_q <= cnt_q - 1'b1;
				if (cnt_q == '0) begin
					run_q  <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			rem_q <= '0;
			quo_q <= dividend;
		end else if (run_q) begin
			rem_q <= ge ? diff[VAL_W-1:0] : trial[VAL_W-1:0];
			quo_q <= {quo_q[VAL_W-2:0], ge};
		end
	end

	assign done      = done_q;
	assign quotient  = quo_q;
	assign remainder = rem_q;

endmodule

[sv/gdb_dp.sv]
// Datapath: denomination registers, counts, largest-slot scan, divider and result register.
module gdb_dp import gdb_pkg::*; (
	input  logic              clk,
	input  logic              arst_n,
	input  req_t              req,
	input  logic              cfg_we,
	input  logic [SLOT_W-1:0] cfg_index,
	input  logic [VAL_W-1:0]  cfg_wdata,
	input  gdb_cmd_t          cmd,
	output gdb_stat_t         stat,
	output logic              done,
	output res_t              res
);

	logic [VAL_W-1:0]  denom_q [SLOTS];
	logic [CNT_W-1:0]  count_q [SLOTS];
	logic [SLOTS-1:0]  used;
	logic [SLOTS-1:0]  taken_q;
	logic              req_type_q;
	logic [VAL_W-1:0]  amount_q;
	logic [VAL_W-1:0]  query_q;
	logic [SLOT_W-1:0] scan_idx_q;
	logic [SLOT_W-1:0] best_idx_q;
	logic [VAL_W-1:0]  best_val_q;
	logic              best_vld_q;
	logic              done_q;
	res_t              res_q;
	logic              div_done;
	logic [VAL_W-1:0]  div_quo;
	logic [VAL_W-1:0]  div_rem;
	logic [CNT_W:0]    sum;
	logic [CNT_W-1:0]  new_count;
	logic              cand;
	logic              q_found;
	logic [CNT_W-1:0]  q_count;

	always_comb begin
		for (int s = 0; s < SLOTS; s++) begin
			used[s] = (s < NUM_DENOM) && (denom_q[s] != '0);
		end
	end

	// lowest matching slot index comes first in the processing order
	always_comb begin
		q_found = 1'b0;
		q_count = '0;
		for (int s = SLOTS - 1; s >= 0; s--) begin
			if (used[s] && denom_q[s] == query_q) begin
				q_found = 1'b1;
				q_count = count_q[s];
			end
		end
	end

	assign cand = used[scan_idx_q] && !taken_q[scan_idx_q]
		&& (!best_vld_q || denom_q[scan_idx_q] > best_val_q);

	assign sum       = {1'b0, count_q[best_idx_q]} + (CNT_W + 1)'(div_quo);
	assign new_count = sum[CNT_W] ? '1 : sum[CNT_W-1:0];

	gdb_div u_div (
		.clk       (clk),
		.arst_n    (arst_n),
		.start     (cmd.div_start),
		.dividend  (amount_q),
		.divisor   (best_val_q),
		.done      (div_done),
		.quotient  (div_quo),
		.remainder (div_rem)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int s = 0; s < SLOTS; s++) begin
				denom_q[s] <= '0;
				count_q[s] <= '0;
			end
			taken_q    <= '0;
			scan_idx_q <= '0;
			best_vld_q <= 1'b0;
			done_q     <= 1'b0;
		end else begin
			done_q <= cmd.emit;
			if (cfg_we) begin
				denom_q[cfg_index] <= cfg_wdata;
			end
			if (cmd.load) begin
				taken_q    <= '0;
				scan_idx_q <= '0;
				best_vld_q <= 1'b0;
			end else if (cmd.scan_step) begin
				scan_idx_q <= scan_idx_q + 1'b1;
				if (cand) begin
					best_vld_q <= 1'b1;
				end
			end else if (cmd.update) begin
				count_q[best_idx_q] <= new_count;
				taken_q[best_idx_q] <= 1'b1;
				best_vld_q          <= 1'b0;
				scan_idx_q          <= '0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			req_type_q <= req.req_type;
			amount_q   <= req.amount_cents;
			query_q    <= req.query_value;
		end else if (cmd.update) begin
			amount_q <= div_rem;
		end
		if (cmd.scan_step && cand) begin
			best_idx_q <= scan_idx_q;
			best_val_q <= denom_q[scan_idx_q];
		end
		if (cmd.emit) begin
			if (req_type_q == REQ_QUERY) begin
				res_q.found          <= q_found;
				res_q.unit_count     <= q_count;
				res_q.leftover_cents <= '0;
			end else begin
				res_q.found          <= 1'b1;
				res_q.unit_count     <= '0;
				res_q.leftover_cents <= amount_q;
			end
		end
	end

	assign stat.scan_last = scan_idx_q == SLOT_W'(SLOTS - 1);
	assign stat.best_vld  = best_vld_q;
	assign stat.div_done  = div_done;
	assign done           = done_q;
	assign res            = res_q;

endmodule

[sv/gdb_ctrl.sv]
// Controller state machine sequencing scan, divide and count update rounds.
module gdb_ctrl import gdb_pkg::*; (
	input  logic      clk,
	input  logic      arst_n,
	input  logic      start,
	input  logic      req_type,
	input  gdb_stat_t stat,
	output gdb_cmd_t  cmd,
	output logic      busy
);

	localparam logic [2:0] ST_IDLE = 3'd0;
	localparam logic [2:0] ST_QRY  = 3'd1;
	localparam logic [2:0] ST_SCAN = 3'd2;
	localparam logic [2:0] ST_PICK = 3'd3;
	localparam logic [2:0] ST_DIV  = 3'd4;

	logic [2:0] state_q;
	logic [2:0] state_d;

	always_comb begin
		state_d = state_q;
		cmd     = '0;
		unique case (state_q)
			ST_IDLE: begin
				if (start) begin
					cmd.load = 1'b1;
					state_d  = (req_type == REQ_QUERY) ? ST_QRY : ST_SCAN;
				end
			end
			ST_QRY: begin
				cmd.emit = 1'b1;
				state_d  = ST_IDLE;
			end
			ST_SCAN: begin
				cmd.scan_step = 1'b1;
				if (stat.scan_last) begin
					state_d = ST_PICK;
				end
			end
			ST_PICK: begin
				if (stat.best_vld) begin
					cmd.div_start = 1'b1;
					state_d       = ST_DIV;
				end else begin
					cmd.emit = 1'b1;
					state_d  = ST_IDLE;
				end
			end
			ST_DIV: begin
				if (stat.div_done) begin
					cmd.update = 1'b1;
					state_d    = ST_SCAN;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	assign busy = state_q != ST_IDLE;

endmodule

[sv/greedy_denomination_breakdown.sv]
// Top level of the greedy denomination breakdown: controller plus datapath.
// Usage:
//   Pulse start with req while busy is low; the transaction is taken at that edge.
//   req.req_type selects add (amount split greedily over the configured slots,
//   largest value first, lower slot first on ties) or query (count of a value).
//   Exactly one result per transaction appears on res for one cycle with done high;
//   the receiver cannot stall it and must capture it in that cycle.
//   busy falls in the same cycle done rises, so a new start may be given then.
// Sequence:
//   Query: the result is emitted directly, with no scan or divide.
//   Add: each used slot costs one round of a slot scan over all 8 slots, one pick
//   step and a pass through the shared serial divider (31 quotient steps, then
//   the count update); a final scan and pick close the add.
// Configuration: cfg_we, cfg_index, cfg_wdata write one denomination register per
//   cycle; the user writes only while busy is low, unenforced. 0 marks a slot unused.
// Reset: arst_n clears all counts and denominations and returns to idle.
module greedy_denomination_breakdown import gdb_pkg::*; (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              start,
	input  req_t              req,
	output logic              busy,
	input  logic              cfg_we,
	input  logic [SLOT_W-1:0] cfg_index,
	input  logic [VAL_W-1:0]  cfg_wdata,
	output logic              done,
	output res_t              res
);

	gdb_cmd_t  cmd;
	gdb_stat_t stat;

	gdb_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (start),
		.req_type (req.req_type),
		.stat     (stat),
		.cmd      (cmd),
		.busy     (busy)
	);

	gdb_dp u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.req       (req),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_wdata (cfg_wdata),
		.cmd       (cmd),
		.stat      (stat),
		.done      (done),
		.res       (res)
	);

endmodule

[sv/gdb_chk.sv]
// Port-level checker for the greedy denomination breakdown, bound to the top level.
module gdb_chk import gdb_pkg::*; (
	input logic clk,
	input logic arst_n,
	input logic start,
	input logic busy,
	input logic done,
	input res_t res
);

	a_accept_busy: assert property (@(posedge clk) disable iff (!arst_n)
		start && !busy |=> busy)
		else $error("busy not raised after accepted transaction");

	a_done_ends_busy: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> !busy && $past(busy))
		else $error("done without a transaction in flight");

	a_busy_fall_done: assert property (@(posedge clk) disable iff (!arst_n)
		$fell(busy) |-> done)
		else $error("transaction ended without a result");

	a_not_found_zero: assert property (@(posedge clk) disable iff (!arst_n)
		done && !res.found |-> res.unit_count == '0 && res.leftover_cents == '0)
		else $error("not-found result carries data");

	a_leftover_add: assert property (@(posedge clk) disable iff (!arst_n)
		done && res.leftover_cents != '0 |-> res.found && res.unit_count == '0)
		else $error("leftover on a non-add result");

endmodule

bind greedy_denomination_breakdown gdb_chk u_chk (.*);

[bench/denomination_checker.sv]
// Checker for the greedy denomination breakdown: mirrors slot writes, predicts and compares results.
`timescale 1ns / 100ps
module denomination_checker import gdb_pkg::*; (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              start,
	input  logic              busy,
	input  req_t              req,
	input  logic              cfg_we,
	input  logic [SLOT_W-1:0] cfg_index,
	input  logic [VAL_W-1:0]  cfg_wdata,
	input  logic              done,
	input  res_t              res,
	output int                mismatches,
	output int                outstanding
);

	logic [VAL_W-1:0] denom_val [SLOTS];
	logic [CNT_W-1:0] tally [SLOTS];
	res_t             pending_results [$];
	res_t             head;
	int               errs = 0;

	// largest value first, lower slot first on equal values
	function automatic res_t breakdown_result(req_t r);
		int               order [SLOTS];
		int               n;
		int               k;
		int               s;
		int               i;
		logic [VAL_W-1:0] amount;
		logic [CNT_W-1:0] quot;
		logic [CNT_W:0]   sum;
		res_t             o;
		n = 0;
		for (s = 0; s < SLOTS; s++) begin
			if (s < NUM_DENOM && denom_val[s] != '0) begin
				k = n;
				while (k > 0 && denom_val[order[k-1]] < denom_val[s]) begin
					order[k] = order[k-1];
					k--;
				end
				order[k] = s;
				n++;
			end
		end
		o = '0;
		if (r.req_type == REQ_ADD) begin
			amount = r.amount_cents;
			for (i = 0; i < n; i++) begin
				quot = CNT_W'(amount / denom_val[order[i]]);
				sum = {1'b0, tally[order[i]]} + {1'b0, quot};
				tally[order[i]] = sum[CNT_W] ? '1 : sum[CNT_W-1:0];
				amount = amount % denom_val[order[i]];
			end
			o.found = 1'b1;
			o.leftover_cents = amount;
		end else begin
			for (i = 0; i < n; i++) begin
				if (!o.found && denom_val[order[i]] == r.query_value) begin
					o.found = 1'b1;
					o.unit_count = tally[order[i]];
				end
			end
		end
		return o;
	endfunction

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			foreach (denom_val[s]) begin
				denom_val[s] = '0;
				tally[s] = '0;
			end
			pending_results.delete();
		end else begin
			if (done) begin
				if (pending_results.size() == 0) begin
					errs++;
					if (errs <= 10)
						$display("%0t: result with no transaction outstanding: found %0b count %0d leftover %0d",
							$time, res.found, res.unit_count, res.leftover_cents);
				end else begin
					head = pending_results.pop_front();
					if (res.found !== head.found || res.unit_count !== head.unit_count ||
							res.leftover_cents !== head.leftover_cents) begin
						errs++;
						if (errs <= 10)
							$display("%0t: mismatch exp/got: found %0b/%0b count %0d/%0d leftover %0d/%0d",
								$time, head.found, res.found, head.unit_count, res.unit_count,
								head.leftover_cents, res.leftover_cents);
					end
				end
			end
			if (cfg_we)
				denom_val[cfg_index] = cfg_wdata;
			if (start && !busy)
				pending_results.push_back(breakdown_result(req));
		end
		outstanding <= pending_results.size();
		mismatches <= errs;
	end

endmodule

[bench/greedy_denomination_breakdown_tb.sv]
// Testbench top for the greedy denomination breakdown: slot writes, add/query stimulus, verdict.
`timescale 1ns / 100ps
module greedy_denomination_breakdown_tb;
	import gdb_pkg::*;

	localparam logic [VAL_W-1:0] VAL_MAX = '1;

	logic              clk = 1'b0;
	logic              arst_n = 1'b0;
	logic              start = 1'b0;
	req_t              req = '0;
	logic              busy;
	logic              cfg_we = 1'b0;
	logic [SLOT_W-1:0] cfg_index = '0;
	logic [VAL_W-1:0]  cfg_wdata = '0;
	logic              done;
	res_t              res;
	int                mismatches;
	int                outstanding;
	logic [VAL_W-1:0]  slot_val [SLOTS];
	bit                no_gaps = 1'b0;

	greedy_denomination_breakdown dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.start     (start),
		.req       (req),
		.busy      (busy),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_wdata (cfg_wdata),
		.done      (done),
		.res       (res)
	);

	denomination_checker tally_check (
		.clk         (clk),
		.arst_n      (arst_n),
		.start       (start),
		.busy        (busy),
		.req         (req),
		.cfg_we      (cfg_we),
		.cfg_index   (cfg_index),
		.cfg_wdata   (cfg_wdata),
		.done        (done),
		.res         (res),
		.mismatches  (mismatches),
		.outstanding (outstanding)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	initial begin
		#25_000_000;
		$display("FAILED: results differ");
		$finish;
	end

	function automatic req_t add_req(logic [VAL_W-1:0] amt);
		req_t r;
		r.req_type = REQ_ADD;
		r.amount_cents = amt;
		r.query_value = VAL_W'($urandom);
		return r;
	endfunction

	function automatic req_t query_req(logic [VAL_W-1:0] v);
		req_t r;
		r.req_type = REQ_QUERY;
		r.amount_cents = VAL_W'($urandom);
		r.query_value = v;
		return r;
	endfunction

	function automatic logic [VAL_W-1:0] pick_amount();
		case ($urandom_range(0, 6))
			0: return VAL_W'($urandom);
			1: return VAL_W'($urandom_range(0, 999));
			2: return VAL_W'($urandom_range(0, 100000));
			3: return VAL_W'(slot_val[$urandom_range(0, SLOTS-1)] * $urandom_range(1, 4)
				+ $urandom_range(0, 3));
			4: return VAL_W'($urandom) >> $urandom_range(0, 30);
			5: return VAL_MAX;
			default: return '0;
		endcase
	endfunction

	function automatic logic [VAL_W-1:0] pick_query();
		case ($urandom_range(0, 7))
			0: return '0;
			1: return VAL_W'($urandom);
			2: return slot_val[$urandom_range(0, SLOTS-1)] + 1'b1;
			default: return slot_val[$urandom_range(0, SLOTS-1)];
		endcase
	endfunction

	task automatic wait_idle();
		start <= 1'b0;
		do @(posedge clk); while (outstanding != 0 || busy);
	endtask

	task automatic load_slots();
		wait_idle();
		for (int i = 0; i < SLOTS; i++) begin
			cfg_we <= 1'b1;
			cfg_index <= SLOT_W'(i);
			cfg_wdata <= slot_val[i];
			@(posedge clk);
		end
		cfg_we <= 1'b0;
	endtask

	task automatic random_config(input int mode);
		logic [VAL_W-1:0] few [3];
		foreach (few[j])
			few[j] = VAL_W'($urandom_range(1, 300));
		foreach (slot_val[i]) begin
			case (mode)
				0: slot_val[i] = VAL_W'($urandom_range(1, 500));
				1: slot_val[i] = VAL_W'($urandom);
				2: slot_val[i] = $urandom_range(0, 1) ? '0 : VAL_W'($urandom_range(1, 10000));
				3: slot_val[i] = $urandom_range(0, 4) == 0 ? '0 : few[$urandom_range(0, 2)];
				default: begin
					case ($urandom_range(0, 3))
						0: slot_val[i] = '0;
						1: slot_val[i] = VAL_MAX;
						2: slot_val[i] = VAL_W'(1);
						default: slot_val[i] = VAL_MAX - VAL_W'($urandom_range(1, 3));
					endcase
				end
			endcase
		end
		load_slots();
	endtask

	task automatic send_item(input req_t r);
		int gap;
		req_t noise;
		gap = no_gaps ? 0 : $urandom_range(0, 13);
		if (gap > 0) begin
			noise.req_type = 1'($urandom_range(0, 1));
			noise.amount_cents = VAL_W'($urandom);
			noise.query_value = VAL_W'($urandom);
			start <= 1'b0;
			req <= noise;
			if ($urandom_range(0, 1))
				do @(posedge clk); while (busy);
			repeat (gap) @(posedge clk);
		end
		start <= 1'b1;
		req <= r;
		do @(posedge clk); while (busy);
	endtask

	initial begin
		foreach (slot_val[i])
			slot_val[i] = '0;
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// no slot in use yet
		send_item(add_req(VAL_MAX));
		send_item(query_req('0));

		// single unit slot, driven into saturation
		slot_val = '{1, 0, 0, 0, 0, 0, 0, 0};
		load_slots();
		send_item(add_req(VAL_MAX));
		send_item(add_req(VAL_MAX));
		send_item(add_req(VAL_MAX));
		send_item(query_req(VAL_W'(1)));
		send_item(add_req('0));
		send_item(query_req('0));

		// slot 0 keeps its saturated count; slots 2 and 4 share a value
		slot_val = '{5, 100, 25, 10, 25, 2000, VAL_MAX, 0};
		load_slots();
		send_item(add_req(VAL_MAX));
		send_item(add_req(VAL_MAX - 1'b1));
		send_item(add_req(VAL_W'(12347)));
		send_item(query_req(VAL_W'(25)));
		send_item(query_req(VAL_W'(5)));
		send_item(query_req(VAL_MAX));
		send_item(query_req(VAL_W'(7)));
		send_item(query_req('0));

		// slot 0 dropped from use
		slot_val[0] = '0;
		load_slots();
		send_item(query_req(VAL_W'(5)));
		send_item(add_req(VAL_W'(1234)));
		send_item(query_req(VAL_W'(100)));

		for (int ph = 0; ph < 8; ph++) begin
			random_config(ph % 5);
			for (int n = 0; n < 155; n++) begin
				if (n % 20 == 0)
					no_gaps = ($urandom_range(0, 3) == 0);
				if ($urandom_range(0, 9) < 6)
					send_item(add_req(pick_amount()));
				else
					send_item(query_req(pick_query()));
			end
		end

		wait_idle();
		repeat (400) @(posedge clk);
		if (mismatches == 0 && outstanding == 0)
			$display("PASSED: all results match");
		else
			$display("FAILED: results differ");
		$finish;
	end

endmodule
